/* rtl/tcs_pkg.sv */
// Shared types, codes and reset constants of the timed command scheduler.
`timescale 1ns / 1ps
`default_nettype none
package tcs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [31:0] LOG_PERIOD_RESET = 32'd1000;
  localparam logic [15:0] LATE_WINDOW_RESET = 16'd10;
  localparam int ENTRY_W = 64;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_START   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_FIRE = 2'd1,
    KIND_LOG  = 2'd2
  } kind_t;

  typedef enum logic {
    REG_LOG_PERIOD  = 1'b0,
    REG_LATE_WINDOW = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] log_period;
    logic [15:0] late_window;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } queue_ctrl_t;

  typedef struct packed {
    kind_t              kind;
    logic               add_status;
    logic signed [31:0] fired_throttle;
    logic [31:0]        event_time;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

/* rtl/tcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcs_ram #(
  parameter int WIDTH = tcs_pkg::ENTRY_W,
  parameter int DEPTH = tcs_pkg::QUEUE_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/tcs_queue.sv */
// Command FIFO: RAM storage with pointers, fill count and a prefetched head word.
`timescale 1ns / 1ps
`default_nettype none
module tcs_queue #(
  parameter int QUEUE_DEPTH = tcs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tcs_pkg::queue_ctrl_t ctrl,
  input  wire logic [31:0]         wr_when,
  input  wire logic signed [31:0]  wr_throttle,
  output logic [31:0]              head_when,
  output logic signed [31:0]       head_throttle,
  output logic                     full,
  output logic                     empty
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [tcs_pkg::ENTRY_W-1:0] ram_rdata;
  logic [tcs_pkg::ENTRY_W-1:0] wr_word;
  logic [tcs_pkg::ENTRY_W-1:0] bypass_word;
  logic bypass;
  logic [tcs_pkg::ENTRY_W-1:0] head_word;

  assign wr_word = {wr_when, wr_throttle};
  assign full = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);

  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    if (ctrl.flush) begin
      head_next = '0;
      tail_next = '0;
      count_next = '0;
    end else begin
      if (ctrl.push) begin
        tail_next = (tail == LAST_IDX) ? '0 : tail + 1'b1;
        count_next = count + 1'b1;
      end
      if (ctrl.pop) begin
        head_next = (head == LAST_IDX) ? '0 : head + 1'b1;
        count_next = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      count <= count_next;
    end
  end

  // The read port always looks at the next head, so the head word is registered
  // and ready in the following cycle; a write to that same entry is forwarded around the RAM.
  always_ff @(posedge clk) begin
    bypass <= ctrl.push && (tail == head_next);
    bypass_word <= wr_word;
  end

  tcs_ram #(
    .WIDTH(tcs_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.push),
    .waddr(tail),
    .wdata(wr_word),
    .raddr(head_next),
    .rdata(ram_rdata)
  );

  assign head_word = bypass ? bypass_word : ram_rdata;
  assign head_when = head_word[63:32];
  assign head_throttle = head_word[31:0];

endmodule
`default_nettype wire

/* rtl/tcs_regs.sv */
// APB configuration registers: log period and late window.
`timescale 1ns / 1ps
`default_nettype none
module tcs_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output tcs_pkg::cfg_t    cfg
);

  tcs_pkg::reg_idx_t idx;
  logic wr_en;

  assign idx = tcs_pkg::reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log_period <= tcs_pkg::LOG_PERIOD_RESET;
      cfg.late_window <= tcs_pkg::LATE_WINDOW_RESET;
    end else if (wr_en) begin
      unique case (idx)
        tcs_pkg::REG_LOG_PERIOD:  cfg.log_period <= pwdata;
        tcs_pkg::REG_LATE_WINDOW: cfg.late_window <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tcs_pkg::REG_LOG_PERIOD:  prdata = cfg.log_period;
      tcs_pkg::REG_LATE_WINDOW: prdata = {16'd0, cfg.late_window};
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/tcs_core.sv */
// Scheduler core: timer, compare slot, log compare and result registers.
`timescale 1ns / 1ps
`default_nettype none
module tcs_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [31:0]         in_task_time,
  input  wire logic signed [31:0]  in_throttle,
  input  wire tcs_pkg::cfg_t       cfg,
  input  wire logic [31:0]         head_when,
  input  wire logic signed [31:0]  head_throttle,
  input  wire logic                q_full,
  input  wire logic                q_empty,
  output tcs_pkg::queue_ctrl_t     q_ctrl,
  output logic                     busy,
  output logic                     result_valid,
  output tcs_pkg::result_t         result
);

  logic [31:0] time_count, time_count_next;
  logic running, running_next;
  logic slot_armed, slot_armed_next;
  logic [31:0] slot_time, slot_time_next;
  logic signed [31:0] pending_throttle, pending_throttle_next;
  logic [31:0] log_compare, log_compare_next;
  logic spill_valid, spill_valid_next;
  tcs_pkg::result_t spill, first_res, second_res;
  logic first_valid;

  tcs_pkg::cmd_t cmd;
  logic process;
  logic is_tick;
  logic [31:0] t_inc;
  logic [31:0] arm_base;
  logic [31:0] arm_when;
  logic signed [31:0] arm_thr;
  logic arm_ok;
  logic log_hit;
  logic fire;

  assign cmd = tcs_pkg::cmd_t'(in_cmd);
  assign process = in_valid && !spill_valid;
  assign busy = spill_valid;
  assign is_tick = (cmd == tcs_pkg::CMD_TICK);
  assign t_inc = time_count + 32'd1;

  // One shared lateness check: an add is tested against the current count,
  // a popped command against the count after the tick.
  assign arm_base = is_tick ? t_inc : time_count;
  assign arm_when = is_tick ? head_when : in_task_time;
  assign arm_thr = is_tick ? head_throttle : in_throttle;
  assign arm_ok = {1'b0, arm_base} < ({1'b0, arm_when} + {17'd0, cfg.late_window});

  assign log_hit = running && (t_inc == log_compare);
  assign fire = running && slot_armed && (t_inc == slot_time);

  always_comb begin
    time_count_next = time_count;
    running_next = running;
    slot_armed_next = slot_armed;
    slot_time_next = slot_time;
    pending_throttle_next = pending_throttle;
    log_compare_next = log_compare;
    q_ctrl = '0;
    first_valid = 1'b0;
    first_res = '0;
    second_res = '0;
    spill_valid_next = 1'b0;

    if (process) begin
      unique case (cmd)
        tcs_pkg::CMD_ADD: begin
          first_valid = 1'b1;
          first_res.kind = tcs_pkg::KIND_ADD;
          first_res.event_time = time_count;
          first_res.last = 1'b1;
          if (!slot_armed) begin
            if (arm_ok) begin
              slot_armed_next = 1'b1;
              slot_time_next = arm_when;
              pending_throttle_next = arm_thr;
            end
          end else if (!q_full) begin
            q_ctrl.push = 1'b1;
          end else begin
            first_res.add_status = 1'b1;
          end
        end
        tcs_pkg::CMD_TICK: begin
          if (running) begin
            time_count_next = t_inc;
            if (log_hit) begin
              log_compare_next = t_inc + cfg.log_period;
            end
            if (fire) begin
              if (!q_empty) begin
                q_ctrl.pop = 1'b1;
                if (arm_ok) begin
                  slot_time_next = arm_when;
                  pending_throttle_next = arm_thr;
                end
              end else begin
                slot_armed_next = 1'b0;
              end
            end
            if (log_hit) begin
              first_valid = 1'b1;
              first_res.kind = tcs_pkg::KIND_LOG;
              first_res.event_time = t_inc;
              first_res.last = !fire;
              if (fire) begin
                spill_valid_next = 1'b1;
                second_res.kind = tcs_pkg::KIND_FIRE;
                second_res.fired_throttle = pending_throttle;
                second_res.event_time = t_inc;
                second_res.last = 1'b1;
              end
            end else if (fire) begin
              first_valid = 1'b1;
              first_res.kind = tcs_pkg::KIND_FIRE;
              first_res.fired_throttle = pending_throttle;
              first_res.event_time = t_inc;
              first_res.last = 1'b1;
            end
          end
        end
        tcs_pkg::CMD_RESTART: begin
          running_next = 1'b0;
          time_count_next = '0;
          log_compare_next = cfg.log_period;
          slot_time_next = '0;
          slot_armed_next = 1'b0;
          q_ctrl.flush = 1'b1;
        end
        tcs_pkg::CMD_START: begin
          running_next = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_count <= '0;
      running <= 1'b0;
      slot_armed <= 1'b0;
      slot_time <= '0;
      pending_throttle <= '0;
      log_compare <= tcs_pkg::LOG_PERIOD_RESET;
      spill_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      time_count <= time_count_next;
      running <= running_next;
      slot_armed <= slot_armed_next;
      slot_time <= slot_time_next;
      pending_throttle <= pending_throttle_next;
      log_compare <= log_compare_next;
      spill_valid <= spill_valid_next;
      result_valid <= spill_valid || first_valid;
    end
  end

  always_ff @(posedge clk) begin
    spill <= second_res;
    result <= spill_valid ? spill : first_res;
  end

endmodule
`default_nettype wire

/* rtl/timed_command_scheduler.sv */
// Top level of the timed command scheduler: input register, core, queue, registers.
//
//  Channel   Signals                                   Handshake
//  -------   ---------------------------------------   -------------------------------
//  command   cmd, task_time, throttle_value            taken when start=1 and busy=0
//  result    kind, add_status, fired_throttle,         each word marked by strobe=1,
//            event_time, last                          no back-pressure
//  config    psel, penable, pwrite, paddr, pwdata,     APB, pready tied high
//            prdata, pready
//
// A command word is registered, then processed once busy is low; its first result
// word appears on the cycle after that. One command per cycle is taken, except that a
// tick giving both a log event and a fired command holds busy high for one cycle while
// the second result word is registered. Reset is synchronous; the queue needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module timed_command_scheduler #(
  parameter int QUEUE_DEPTH = tcs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic [31:0]        task_time,
  input  wire logic signed [31:0] throttle_value,
  output logic                    strobe,
  output logic [1:0]              kind,
  output logic                    add_status,
  output logic signed [31:0]      fired_throttle,
  output logic [31:0]             event_time,
  output logic                    last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic in_valid;
  logic [1:0] in_cmd;
  logic [31:0] in_task_time;
  logic signed [31:0] in_throttle;
  logic accept;

  tcs_pkg::cfg_t cfg;
  tcs_pkg::queue_ctrl_t q_ctrl;
  tcs_pkg::result_t result;
  logic [31:0] head_when;
  logic signed [31:0] head_throttle;
  logic q_full;
  logic q_empty;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (!busy) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd <= cmd;
      in_task_time <= task_time;
      in_throttle <= throttle_value;
    end
  end

  tcs_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  tcs_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (q_ctrl),
    .wr_when      (in_task_time),
    .wr_throttle  (in_throttle),
    .head_when    (head_when),
    .head_throttle(head_throttle),
    .full         (q_full),
    .empty        (q_empty)
  );

  tcs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_cmd       (in_cmd),
    .in_task_time (in_task_time),
    .in_throttle  (in_throttle),
    .cfg          (cfg),
    .head_when    (head_when),
    .head_throttle(head_throttle),
    .q_full       (q_full),
    .q_empty      (q_empty),
    .q_ctrl       (q_ctrl),
    .busy         (busy),
    .result_valid (strobe),
    .result       (result)
  );

  assign kind = result.kind;
  assign add_status = result.add_status;
  assign fired_throttle = result.fired_throttle;
  assign event_time = result.event_time;
  assign last = result.last;

endmodule
`default_nettype wire
